/* rtl/order_table_with_pretrade_risk_unit_defines.svh */
// assertion macros for the order table block
`ifndef ORDER_TABLE_WITH_PRETRADE_RISK_UNIT_DEFINES_SVH
`define ORDER_TABLE_WITH_PRETRADE_RISK_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define OTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/otr_pkg.sv */
// ----------------------------------------------------------------------------
// otr_pkg
// types and constants shared by the order table block
// ----------------------------------------------------------------------------
package otr_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    typedef enum logic [2:0] {
        REQ_SUBMIT     = 3'd0,
        REQ_CANCEL     = 3'd1,
        REQ_CANCEL_ALL = 3'd2,
        REQ_REPLACE    = 3'd3,
        REQ_FILL       = 3'd4
    } t_req;

    typedef enum logic [3:0] {
        RSN_OK         = 4'd0,
        RSN_PRICE      = 4'd1,
        RSN_MIN_QTY    = 4'd2,
        RSN_TICK       = 4'd3,
        RSN_INVENTORY  = 4'd4,
        RSN_BUY_CROSS  = 4'd5,
        RSN_SELL_CROSS = 4'd6,
        RSN_NOT_ACTIVE = 4'd7,
        RSN_TABLE_FULL = 4'd8
    } t_reason;

    localparam logic [1:0] CFG_MAX_INV = 2'd0;
    localparam logic [1:0] CFG_MIN_QTY = 2'd1;
    localparam logic [1:0] CFG_TICK    = 2'd2;
    localparam logic [1:0] CFG_STRICT  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_DECIDE, ST_DIV, ST_RISK, ST_CHECK, ST_EMIT,
        ST_SCAN_RD, ST_SCAN_CHK, ST_SCAN_EMIT, ST_SCAN_WAIT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

/* rtl/otr_urem.sv */
// ----------------------------------------------------------------------------
// otr_urem
// restoring remainder unit, one quotient bit per cycle (32 bits by 16 bits)
// ----------------------------------------------------------------------------
module otr_urem (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_dividend,
    input  logic [15:0]         i_divisor,
    output otr_pkg::t_div_ctl   o_ctl,
    output logic                o_zero
);
    logic [31:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_sh;
    logic [16:0] w_sub;

    assign w_sh  = {r_rem[15:0], r_num[31]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            // zero divisor counts as one
            r_den <= (i_divisor == 16'd0) ? 16'd1 : i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= w_sub[16] ? w_sh : w_sub;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_zero      = (r_rem == 17'd0);
endmodule

/* rtl/order_table_with_pretrade_risk_unit.sv */
// ----------------------------------------------------------------------------
// order_table_with_pretrade_risk_unit
// order table with pre-trade risk checks, slot contents held in one memory
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: req_type strategy is_sell price quantity target_id
//                inventory top_bid bid_known top_ask ask_known
// m_axis    out  tdata: result_id id_valid accepted reason_code; tlast: last
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// one request at a time; the next one is taken once the output register is empty.
// ignored types are answered from the read state, cancel and fill from decide;
// submit starts the tick remainder unit, waits for it, then passes risk, check
// and emit; a live replace does so after decide. cancel all walks every slot via
// scan read, check and wait, and scan emit on a hit; each hit is held back until
// the next one or the end of the walk decides last. output stalls hold the walk.
// reset clears active bits and exposure, sets next id to 1; slot contents are not
// cleared. the table depth is a power of two, the slot is the low bits of the id.
module order_table_with_pretrade_risk_unit #(
    parameter int TABLE_DEPTH = otr_pkg::TABLE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[2:0] strategy[18:3] is_sell[19] price[51:20] quantity[83:52]
    // target_id[115:84] inventory[147:116] top_bid[179:148] bid_known[180]
    // top_ask[212:181] ask_known[213], zero to 215
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_id[31:0] id_valid[32] accepted[33] reason_code[37:34], zero to 39
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [30:0]  i_cfg_data
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = 32 + 16 + 1 + 32;

    // configuration
    logic [30:0] r_max_inv, r_min_qty;
    logic [15:0] r_tick;
    logic        r_strict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_inv <= '0;
            r_min_qty <= 31'd1;
            r_tick    <= 16'd1;
            r_strict  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                otr_pkg::CFG_MAX_INV: r_max_inv <= i_cfg_data;
                otr_pkg::CFG_MIN_QTY: r_min_qty <= i_cfg_data;
                otr_pkg::CFG_TICK:    r_tick    <= i_cfg_data[15:0];
                otr_pkg::CFG_STRICT:  r_strict  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // slot memory: tag, strategy, sell, remaining
    logic [EW-1:0]          mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_active;
    logic [EW-1:0]          r_rd;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa, mem_ra;
    logic [EW-1:0]          mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    logic [31:0] e_tag, e_rem;
    logic [15:0] e_strat;
    logic        e_sell;
    assign e_tag   = r_rd[31:0];
    assign e_strat = r_rd[47:32];
    assign e_sell  = r_rd[48];
    assign e_rem   = r_rd[80:49];

    // latched request
    logic [2:0]  r_type;
    logic [15:0] r_strat;
    logic        r_sell;
    logic signed [31:0] r_price, r_qty, r_inv, r_bid, r_ask;
    logic [31:0] r_target;
    logic        r_bidk, r_askk;

    otr_pkg::t_state r_state, n_state;
    logic [31:0] r_next_id;
    logic signed [39:0] r_expo;
    logic [AW:0]   r_scan;
    logic          r_found;
    logic [3:0]    r_rsn;
    logic signed [39:0] r_proj;

    // output register; r_hold keeps a cancel-all hit back until last is known
    logic        r_ov, r_olast, r_oidv, r_oacc, r_hold;
    logic [31:0] r_oid;
    logic [3:0]  r_orsn;

    // remainder unit
    logic             div_start;
    otr_pkg::t_div_ctl div_ctl;
    logic             div_zero;
    otr_urem u_rem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_price), .i_divisor(r_tick), .o_ctl(div_ctl), .o_zero(div_zero)
    );

    logic signed [39:0] w_sq, w_ret;
    assign w_sq  = r_sell ? -40'(r_qty) : 40'(r_qty);
    assign w_ret = e_sell ? -$signed({8'd0, e_rem}) : $signed({8'd0, e_rem});

    logic [AW-1:0] w_nslot, w_tslot;
    assign w_nslot = r_next_id[AW-1:0];
    assign w_tslot = r_target[AW-1:0];

    assign s_axis_tready = (r_state == otr_pkg::ST_IDLE) && !r_ov;
    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // load and show requests for the output register
    logic        em, em_show, em_fin, em_last, em_idv, em_acc;
    logic [31:0] em_id;
    logic [3:0]  em_rsn;
    logic        ld_proj, ld_chk, cl_act, set_act, ld_found, sc_inc, sub_exp, add_exp;
    logic        ld_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= otr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        em = 1'b0; em_show = 1'b0; em_fin = 1'b0;
        em_last = 1'b1; em_idv = 1'b0; em_acc = 1'b0;
        em_id = '0; em_rsn = otr_pkg::RSN_OK;
        mem_we = 1'b0; mem_wa = w_nslot;
        mem_wd = {r_qty, r_sell, r_strat, r_next_id};
        mem_ra = w_tslot;
        div_start = 1'b0;
        ld_proj = 1'b0; ld_chk = 1'b0; cl_act = 1'b0; set_act = 1'b0;
        ld_found = 1'b0; sc_inc = 1'b0; sub_exp = 1'b0; add_exp = 1'b0; ld_id = 1'b0;
        case (r_state)
            otr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = otr_pkg::ST_RD;
                end
            end
            otr_pkg::ST_RD: begin
                // memory read of the target slot
                mem_ra = w_tslot;
                case (r_type)
                    otr_pkg::REQ_SUBMIT: begin
                        div_start = 1'b1;
                        n_state = otr_pkg::ST_DIV;
                    end
                    otr_pkg::REQ_CANCEL, otr_pkg::REQ_FILL, otr_pkg::REQ_REPLACE:
                        n_state = otr_pkg::ST_DECIDE;
                    otr_pkg::REQ_CANCEL_ALL: n_state = otr_pkg::ST_SCAN_RD;
                    default: begin
                        em = 1'b1; em_show = 1'b1;
                        n_state = otr_pkg::ST_IDLE;
                    end
                endcase
            end
            otr_pkg::ST_DECIDE: begin
                if (!(r_active[w_tslot] && e_tag == r_target)) begin
                    em = 1'b1; em_show = 1'b1; em_rsn = otr_pkg::RSN_NOT_ACTIVE;
                    n_state = otr_pkg::ST_IDLE;
                end else begin
                    cl_act = 1'b1; sub_exp = 1'b1;
                    if (r_type == otr_pkg::REQ_REPLACE) begin
                        ld_found = 1'b1;
                        div_start = 1'b1;
                        n_state = otr_pkg::ST_DIV;
                    end else begin
                        em = 1'b1; em_show = 1'b1; em_idv = 1'b1; em_acc = 1'b1;
                        em_id = r_target;
                        n_state = otr_pkg::ST_IDLE;
                    end
                end
            end
            otr_pkg::ST_DIV: begin
                if (!div_ctl.busy && !div_ctl.start) begin
                    n_state = otr_pkg::ST_RISK;
                end
            end
            otr_pkg::ST_RISK: begin
                ld_proj = 1'b1;
                n_state = otr_pkg::ST_CHECK;
            end
            otr_pkg::ST_CHECK: begin
                ld_chk = 1'b1;
                n_state = otr_pkg::ST_EMIT;
            end
            otr_pkg::ST_EMIT: begin
                em = 1'b1; em_show = 1'b1; em_idv = 1'b1; em_id = r_next_id;
                em_rsn = r_rsn;
                em_acc = (r_rsn == otr_pkg::RSN_OK);
                ld_id = 1'b1;
                if (r_rsn == otr_pkg::RSN_OK) begin
                    mem_we = 1'b1; set_act = 1'b1; add_exp = 1'b1;
                end
                n_state = otr_pkg::ST_IDLE;
            end
            otr_pkg::ST_SCAN_RD: begin
                mem_ra = r_scan[AW-1:0];
                n_state = otr_pkg::ST_SCAN_CHK;
            end
            otr_pkg::ST_SCAN_CHK: begin
                mem_ra = r_scan[AW-1:0];
                if (r_active[r_scan[AW-1:0]] && e_strat == r_strat) begin
                    n_state = otr_pkg::ST_SCAN_EMIT;
                end else begin
                    sc_inc = 1'b1;
                    n_state = otr_pkg::ST_SCAN_WAIT;
                end
            end
            otr_pkg::ST_SCAN_EMIT: begin
                // keep the slot data in the read register while waiting
                mem_ra = r_scan[AW-1:0];
                if (!r_ov) begin
                    if (r_hold) begin
                        // a later hit exists, so the held one is not last
                        em_show = 1'b1;
                    end else begin
                        em = 1'b1; em_idv = 1'b1; em_acc = 1'b1; em_id = e_tag;
                        em_last = 1'b0; cl_act = 1'b1; sub_exp = 1'b1; ld_found = 1'b1;
                        sc_inc = 1'b1;
                        n_state = otr_pkg::ST_SCAN_WAIT;
                    end
                end
            end
            otr_pkg::ST_SCAN_WAIT: begin
                if (r_scan == (AW+1)'(TABLE_DEPTH)) begin
                    if (!r_ov) begin
                        if (!r_found) begin
                            em = 1'b1; em_show = 1'b1; em_rsn = otr_pkg::RSN_NOT_ACTIVE;
                        end else begin
                            // the held hit is the final transaction of the walk
                            em_show = 1'b1; em_fin = 1'b1;
                        end
                        n_state = otr_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = otr_pkg::ST_SCAN_RD;
                end
            end
            default: n_state = otr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_next_id <= 32'd1;
            r_expo    <= '0;
            r_ov      <= 1'b0;
            r_hold    <= 1'b0;
            r_found   <= 1'b0;
            r_scan    <= '0;
        end else begin
            if (in_acc) begin
                r_found <= 1'b0;
                r_scan  <= '0;
            end
            if (sc_inc) r_scan <= r_scan + 1'b1;
            if (ld_found) r_found <= 1'b1;
            if (cl_act) r_active[(r_state == otr_pkg::ST_DECIDE) ? w_tslot
                                 : r_scan[AW-1:0]] <= 1'b0;
            if (set_act) r_active[w_nslot] <= 1'b1;
            if (ld_id) r_next_id <= r_next_id + 32'd1;
            if (sub_exp) r_expo <= r_expo - w_ret;
            if (add_exp) r_expo <= r_expo + w_sq;
            if (em_show) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (em_show) begin
                r_hold <= 1'b0;
            end else if (em) begin
                r_hold <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_type   <= s_axis_tdata[2:0];
            r_strat  <= s_axis_tdata[18:3];
            r_sell   <= s_axis_tdata[19];
            r_price  <= s_axis_tdata[51:20];
            r_qty    <= s_axis_tdata[83:52];
            r_target <= s_axis_tdata[115:84];
            r_inv    <= s_axis_tdata[147:116];
            r_bid    <= s_axis_tdata[179:148];
            r_bidk   <= s_axis_tdata[180];
            r_ask    <= s_axis_tdata[212:181];
            r_askk   <= s_axis_tdata[213];
        end
        if (r_state == otr_pkg::ST_DECIDE && r_type == otr_pkg::REQ_REPLACE) begin
            r_strat <= e_strat;
            r_sell  <= e_sell;
        end
        if (ld_proj) r_proj <= 40'(r_inv) + r_expo + w_sq;
        if (ld_chk) begin
            if (r_price <= 0) r_rsn <= otr_pkg::RSN_PRICE;
            else if (r_qty < $signed({1'b0, r_min_qty})) r_rsn <= otr_pkg::RSN_MIN_QTY;
            else if (!div_zero) r_rsn <= otr_pkg::RSN_TICK;
            else if (((r_proj < 0) ? -r_proj : r_proj) > 40'(r_max_inv))
                r_rsn <= otr_pkg::RSN_INVENTORY;
            else if (r_strict && !r_sell && r_askk && r_price >= r_ask)
                r_rsn <= otr_pkg::RSN_BUY_CROSS;
            else if (r_strict && r_sell && r_bidk && r_price <= r_bid)
                r_rsn <= otr_pkg::RSN_SELL_CROSS;
            else if (r_active[w_nslot]) r_rsn <= otr_pkg::RSN_TABLE_FULL;
            else r_rsn <= otr_pkg::RSN_OK;
        end
        if (em) begin
            r_oid   <= em_id;
            r_oidv  <= em_idv;
            r_oacc  <= em_acc;
            r_orsn  <= em_rsn;
            r_olast <= em_last;
        end else if (em_fin) begin
            r_olast <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {2'b00, r_orsn, r_oacc, r_oidv, r_oid};
endmodule

/* rtl/otr_checker.sv */
// ----------------------------------------------------------------------------
// otr_checker
// port-level checks on the order table block
// ----------------------------------------------------------------------------
`include "order_table_with_pretrade_risk_unit_defines.svh"
module otr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic         m_axis_tlast
);
    `OTR_ASSERT_IMP(a_rej_flag, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[33] && m_axis_tdata[37:34] == 4'd0 && m_axis_tdata[32], 1'b0, "rejected result with ok reason")
    `OTR_ASSERT_IMP(a_noid, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0 && m_axis_tlast, "result without id not single")
    `OTR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready && m_axis_tlast, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `OTR_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")
endmodule

bind order_table_with_pretrade_risk_unit otr_checker u_otr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
